// File: rtl/arf_pkg.sv
// Package with shared types, constants and codes for the adaptive refresh interval block.
`timescale 1ns / 1ps

package arf_pkg;

   localparam int TimeW     = 64;
   localparam int IntvW     = 18;
   localparam int BaseW     = 17;
   localparam int PctW      = 7;
   localparam int CsrIdxW   = 3;
   localparam int CsrDataW  = 18;
   localparam int ProdW     = TimeW + PctW;
   localparam int NextW     = IntvW + 1;
   localparam int ScaleW    = 22;
   localparam int RecipW    = 20;
   localparam int RecipProdW = ScaleW + RecipW;
   localparam int RecipShift = 23;
   localparam int DivSteps  = PctW;
   localparam int CntW      = 3;

   localparam logic [RecipW-1:0] RECIP_TEN    = RecipW'(838860);
   localparam logic [ScaleW-1:0] TEN          = ScaleW'(10);
   localparam logic [PctW-1:0]   LOAD_FULL    = PctW'(100);
   localparam logic              MODE_RESTART = 1'b1;

   localparam logic              RST_ENABLE = 1'b1;
   localparam logic [BaseW-1:0]  RST_BASE   = BaseW'(3000);
   localparam logic [PctW-1:0]   RST_HIGH   = PctW'(22);
   localparam logic [PctW-1:0]   RST_LOW    = PctW'(18);
   localparam logic [IntvW-1:0]  RST_MIN    = IntvW'(1000);
   localparam logic [IntvW-1:0]  RST_MAX    = IntvW'(100000);
   localparam logic [IntvW-1:0]  RST_INTV   = IntvW'(3000);

   typedef enum logic [CsrIdxW-1:0] {
      CSR_ENABLE = 3'd0,
      CSR_BASE   = 3'd1,
      CSR_HIGH   = 3'd2,
      CSR_LOW    = 3'd3,
      CSR_MIN    = 3'd4,
      CSR_MAX    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic             enable;
      logic [BaseW-1:0] base_interval;
      logic [PctW-1:0]  high_threshold;
      logic [PctW-1:0]  low_threshold;
      logic [IntvW-1:0] min_interval;
      logic [IntvW-1:0] max_interval;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic delta;
      logic load_direct;
      logic mul_hi;
      logic mul_lo;
      logic div_step;
      logic decide;
      logic recip;
      logic fix;
      logic clamp_base;
      logic clamp_abs;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic direct;
      logic out_free;
   } sts_type;

endpackage

// File: rtl/arf_req_if.sv
// Request channel interface carrying the counter snapshots.
`timescale 1ns / 1ps

interface arf_req_if;
   import arf_pkg::*;

   logic              valid;
   logic              ready;
   logic              mode;
   logic [TimeW-1:0]  total_time;
   logic [TimeW-1:0]  busy_time;

   modport source (output valid, output mode, output total_time, output busy_time,
                   input ready);
   modport sink   (input valid, input mode, input total_time, input busy_time,
                   output ready);
endinterface

// File: rtl/arf_rsp_if.sv
// Result channel interface carrying the interval, change flag and load.
`timescale 1ns / 1ps

interface arf_rsp_if;
   import arf_pkg::*;

   logic              valid;
   logic              ready;
   logic [IntvW-1:0]  interval;
   logic              changed;
   logic [PctW-1:0]   load_percent;

   modport source (output valid, output interval, output changed, output load_percent,
                   input ready);
   modport sink   (input valid, input interval, input changed, input load_percent,
                   output ready);
endinterface

// File: rtl/arf_csr.sv
// Configuration register file written through the plain write port.
`timescale 1ns / 1ps

module arf_csr
   import arf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   output cfg_type             cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ENABLE: cfg_in.enable         = csr_wdata[0];
            CSR_BASE:   cfg_in.base_interval  = csr_wdata[BaseW-1:0];
            CSR_HIGH:   cfg_in.high_threshold = csr_wdata[PctW-1:0];
            CSR_LOW:    cfg_in.low_threshold  = csr_wdata[PctW-1:0];
            CSR_MIN:    cfg_in.min_interval   = csr_wdata[IntvW-1:0];
            CSR_MAX:    cfg_in.max_interval   = csr_wdata[IntvW-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable         <= RST_ENABLE;
         cfg_ff.base_interval  <= RST_BASE;
         cfg_ff.high_threshold <= RST_HIGH;
         cfg_ff.low_threshold  <= RST_LOW;
         cfg_ff.min_interval   <= RST_MIN;
         cfg_ff.max_interval   <= RST_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/arf_ctrl.sv
// Controller state machine that sequences the datapath for one request.
`timescale 1ns / 1ps

module arf_ctrl
   import arf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [11:0] {
      S_IDLE    = 12'b0000_0000_0001,
      S_DELTA   = 12'b0000_0000_0010,
      S_LOAD    = 12'b0000_0000_0100,
      S_MULHI   = 12'b0000_0000_1000,
      S_MULLO   = 12'b0000_0001_0000,
      S_DIV     = 12'b0000_0010_0000,
      S_DECIDE  = 12'b0000_0100_0000,
      S_RECIP   = 12'b0000_1000_0000,
      S_FIX     = 12'b0001_0000_0000,
      S_CLBASE  = 12'b0010_0000_0000,
      S_CLABS   = 12'b0100_0000_0000,
      S_DONE    = 12'b1000_0000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DELTA;
            end
         end
         S_DELTA: begin
            cmd.delta = 1'b1;
            state_in  = sts.skip ? S_DONE : S_LOAD;
         end
         S_LOAD: begin
            if (sts.direct) begin
               cmd.load_direct = 1'b1;
               state_in        = S_DECIDE;
            end else begin
               state_in = S_MULHI;
            end
         end
         S_MULHI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_MULLO;
         end
         S_MULLO: begin
            cmd.mul_lo = 1'b1;
            cnt_in     = CntW'(DivSteps - 1);
            state_in   = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = S_RECIP;
         end
         S_RECIP: begin
            cmd.recip = 1'b1;
            state_in  = S_FIX;
         end
         S_FIX: begin
            cmd.fix  = 1'b1;
            state_in = S_CLBASE;
         end
         S_CLBASE: begin
            cmd.clamp_base = 1'b1;
            state_in       = S_CLABS;
         end
         S_CLABS: begin
            cmd.clamp_abs = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// File: rtl/arf_dp.sv
// Datapath with the load divider, interval scaling, clamps, state and result register.
`timescale 1ns / 1ps

module arf_dp
   import arf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic              req_mode,
   input  logic [TimeW-1:0]  req_total_time,
   input  logic [TimeW-1:0]  req_busy_time,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [IntvW-1:0]  rsp_interval,
   output logic              rsp_changed,
   output logic [PctW-1:0]   rsp_load_percent
);

   logic                   mode_ff;
   logic [TimeW-1:0]       total_ff, busy_ff;
   logic [TimeW-1:0]       td_ff, bd_ff;
   logic [ProdW-1:0]       prod_ff, div_ff;
   logic [PctW-1:0]        load_ff;
   logic                   grow_ff, shrink_ff;
   logic [ScaleW-1:0]      scale_ff;
   logic [RecipProdW-1:0]  rp_ff;
   logic [NextW-1:0]       nxt_ff;

   logic [IntvW-1:0]       cur_ff;
   logic [PctW-1:0]        prev_ff;
   logic [TimeW-1:0]       last_total_ff, last_busy_ff;

   logic                   rsp_valid_ff;
   logic [IntvW-1:0]       rsp_interval_ff;
   logic                   rsp_changed_ff;
   logic [PctW-1:0]        rsp_load_ff;

   logic                   div_ge;
   logic [PctW-1:0]        low_sat;
   logic                   grow_in, shrink_in;
   logic [NextW-1:0]       q_est, q_fix;
   logic [ScaleW-1:0]      q_times_ten, rem;
   logic [NextW-1:0]       base_ext, base_dbl;
   logic [NextW-1:0]       min_ext, max_ext;
   logic [IntvW-1:0]       fin;

   assign div_ge  = (prod_ff >= div_ff);
   assign low_sat = (cfg.low_threshold > LOAD_FULL) ? LOAD_FULL : cfg.low_threshold;

   assign grow_in   = (load_ff > cfg.high_threshold) && (prev_ff > cfg.high_threshold);
   assign shrink_in = !grow_in && (cur_ff != IntvW'(cfg.base_interval)) &&
                      (load_ff < cfg.low_threshold) && (prev_ff < cfg.low_threshold);

   assign q_est       = rp_ff[RecipShift +: NextW];
   assign q_times_ten = ScaleW'({q_est, 3'b000}) + ScaleW'({q_est, 1'b0});
   assign rem         = scale_ff - q_times_ten;
   assign q_fix       = (rem >= TEN) ? q_est + 1'b1 : q_est;

   assign base_ext = NextW'(cfg.base_interval);
   assign base_dbl = NextW'({cfg.base_interval, 1'b0});
   assign min_ext  = NextW'(cfg.min_interval);
   assign max_ext  = NextW'(cfg.max_interval);
   assign fin      = nxt_ff[IntvW-1:0];

   assign sts.skip     = (mode_ff == MODE_RESTART) || !cfg.enable;
   assign sts.direct   = (td_ff == '0) || (bd_ff >= td_ff);
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= req_mode;
         total_ff <= req_total_time;
         busy_ff  <= req_busy_time;
      end
      if (cmd.delta) begin
         td_ff <= total_ff - last_total_ff;
         bd_ff <= busy_ff - last_busy_ff;
      end
      if (cmd.load_direct) begin
         load_ff <= (td_ff == '0) ? low_sat : LOAD_FULL;
      end
      if (cmd.mul_hi) begin
         prod_ff <= ProdW'({bd_ff, 6'b0}) + ProdW'({bd_ff, 5'b0});
      end
      if (cmd.mul_lo) begin
         prod_ff <= prod_ff + ProdW'({bd_ff, 2'b0});
         div_ff  <= ProdW'({td_ff, 6'b0});
         load_ff <= '0;
      end
      if (cmd.div_step) begin
         if (div_ge) begin
            prod_ff <= prod_ff - div_ff;
         end
         load_ff <= {load_ff[PctW-2:0], div_ge};
         div_ff  <= div_ff >> 1;
      end
      if (cmd.decide) begin
         grow_ff   <= grow_in;
         shrink_ff <= shrink_in;
         if (grow_in) begin
            scale_ff <= ScaleW'({cur_ff, 3'b000}) + ScaleW'({cur_ff, 1'b0}) + ScaleW'(cur_ff);
         end else begin
            scale_ff <= ScaleW'({cur_ff, 3'b000}) + ScaleW'(cur_ff);
         end
      end
      if (cmd.recip) begin
         rp_ff <= scale_ff * RECIP_TEN;
      end
      if (cmd.fix) begin
         nxt_ff <= (grow_ff || shrink_ff) ? q_fix : NextW'(cur_ff);
      end
      if (cmd.clamp_base) begin
         if (nxt_ff > base_dbl) begin
            nxt_ff <= base_dbl;
         end else if (nxt_ff < base_ext) begin
            nxt_ff <= base_ext;
         end
      end
      if (cmd.clamp_abs) begin
         if (nxt_ff > max_ext) begin
            nxt_ff <= max_ext;
         end else if (nxt_ff < min_ext) begin
            nxt_ff <= min_ext;
         end
      end
      if (cmd.commit) begin
         if (mode_ff == MODE_RESTART) begin
            rsp_interval_ff <= IntvW'(cfg.base_interval);
            rsp_changed_ff  <= 1'b0;
            rsp_load_ff     <= '0;
         end else if (!cfg.enable) begin
            rsp_interval_ff <= cur_ff;
            rsp_changed_ff  <= 1'b0;
            rsp_load_ff     <= '0;
         end else begin
            rsp_interval_ff <= fin;
            rsp_changed_ff  <= (fin != cur_ff);
            rsp_load_ff     <= load_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff        <= RST_INTV;
         prev_ff       <= RST_LOW;
         last_total_ff <= '0;
         last_busy_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
            if (mode_ff == MODE_RESTART) begin
               cur_ff        <= IntvW'(cfg.base_interval);
               prev_ff       <= cfg.low_threshold;
               last_total_ff <= total_ff;
               last_busy_ff  <= busy_ff;
            end else if (cfg.enable) begin
               cur_ff        <= fin;
               prev_ff       <= load_ff;
               last_total_ff <= total_ff;
               last_busy_ff  <= busy_ff;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_interval     = rsp_interval_ff;
   assign rsp_changed      = rsp_changed_ff;
   assign rsp_load_percent = rsp_load_ff;

endmodule

// File: rtl/adaptive_refresh_interval.sv
// Top level of the adaptive refresh interval block.
`timescale 1ns / 1ps

// Each request on req_if carries a mode bit and two free-running 64-bit counter
// snapshots. A restart request takes the snapshots as the new baseline and sets the
// interval back to the base interval. An enabled sample measures the load percent
// since the last baseline and grows or shrinks the interval within its limits.
// Every request yields exactly one response on rsp_if with the interval, a change
// flag and the measured load.
// A sample that needs the load division passes through the multiply, divide, decide,
// reciprocal, fix and clamp steps to the response register; a direct-load sample
// skips the multiply and divide, and a restart or a disabled sample skips them all.
// The seven-step restoring divider for the load percent sets the longest path through
// the sequence. One request is in flight at a time, so a new request is accepted only
// after the response register loads.
// The result sits in an output register, so the next request is accepted while the
// previous response still waits; a stalled receiver holds the response and the
// following request waits at the last step until the output register frees up.
// Reset restores the configuration registers, interval and baseline to reset values.
// Configuration is written through csr_we, csr_index and csr_wdata; the user must
// do so only while no request is in flight, which the block does not enforce.

module adaptive_refresh_interval
   import arf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   arf_req_if.sink             req_if,
   arf_rsp_if.source           rsp_if,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   arf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   arf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   arf_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .sts              (sts),
      .req_mode         (req_if.mode),
      .req_total_time   (req_if.total_time),
      .req_busy_time    (req_if.busy_time),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_interval     (rsp_if.interval),
      .rsp_changed      (rsp_if.changed),
      .rsp_load_percent (rsp_if.load_percent)
   );

endmodule

// File: bench/tb.sv
// Self-checking testbench for the adaptive refresh interval block.
`timescale 1ns / 1ps

module tb;
   import arf_pkg::*;

   localparam logic MODE_SAMPLE = 1'b0;
   localparam int   CYCLE_LIMIT = 400000;
   localparam int   IDLE_PCT    = 35;
   localparam int   HOLD_AT     = 1200;
   localparam int   HOLD_CYCLES = 400;

   typedef struct packed {
      logic             mode;
      logic [TimeW-1:0] total;
      logic [TimeW-1:0] busy;
   } snapshot_type;

   typedef struct packed {
      logic [IntvW-1:0] interval;
      logic             changed;
      logic [PctW-1:0]  load;
   } report_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_we = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = CSR_ENABLE;
   logic [CsrDataW-1:0] csr_wdata = '0;

   arf_req_if req_ch ();
   arf_rsp_if rsp_ch ();

   adaptive_refresh_interval uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // Shadow copy of the configuration and the adaptation state.
   logic             m_enable     = RST_ENABLE;
   logic [BaseW-1:0] m_base       = RST_BASE;
   logic [PctW-1:0]  m_high       = RST_HIGH;
   logic [PctW-1:0]  m_low        = RST_LOW;
   logic [IntvW-1:0] m_min        = RST_MIN;
   logic [IntvW-1:0] m_max        = RST_MAX;
   logic [IntvW-1:0] m_intv       = RST_INTV;
   logic [PctW-1:0]  m_prev_load  = RST_LOW;
   logic [TimeW-1:0] m_last_total = '0;
   logic [TimeW-1:0] m_last_busy  = '0;

   snapshot_type     queued_snaps[$];
   report_type       due_reports[$];
   snapshot_type     drive_snap;
   report_type       want;
   logic [TimeW-1:0] run_total = '0;
   logic [TimeW-1:0] run_busy  = '0;
   logic             req_fire  = 1'b0;
   int               req_count = 0;
   int               cycle_count = 0;
   int               fail_count = 0;
   int               hold_left = 0;
   logic             hold_done = 1'b0;
   logic             steady;

   assign steady = (req_count >= 500) && (req_count < 800);

   function automatic report_type advance_interval(snapshot_type s);
      logic [TimeW-1:0]   td;
      logic [TimeW-1:0]   bd;
      logic [2*TimeW-1:0] quot;
      longint unsigned    load;
      longint unsigned    nxt;
      longint unsigned    upper;
      report_type         r;
      r = '0;
      if (s.mode == MODE_RESTART) begin
         m_intv = IntvW'(m_base);
         m_prev_load = m_low;
         m_last_total = s.total;
         m_last_busy = s.busy;
      end else if (m_enable) begin
         td = s.total - m_last_total;
         bd = s.busy - m_last_busy;
         if (td == '0) begin
            load = m_low;
         end else if (bd >= td) begin
            load = 100;
         end else begin
            quot = {{TimeW{1'b0}}, bd};
            quot = quot * 100;
            quot = quot / {{TimeW{1'b0}}, td};
            load = quot[TimeW-1:0];
         end
         if (load > 100) load = 100;
         m_last_total = s.total;
         m_last_busy = s.busy;
         nxt = m_intv;
         if (load > m_high && m_prev_load > m_high) begin
            nxt = nxt * 11 / 10;
         end else if (m_intv != IntvW'(m_base) && load < m_low && m_prev_load < m_low) begin
            nxt = nxt * 9 / 10;
         end
         upper = m_base;
         upper = upper * 2;
         if (nxt > upper) nxt = upper;
         else if (nxt < m_base) nxt = m_base;
         if (nxt > m_max) nxt = m_max;
         else if (nxt < m_min) nxt = m_min;
         if (nxt[IntvW-1:0] != m_intv) begin
            r.changed = 1'b1;
            m_intv = nxt[IntvW-1:0];
         end
         m_prev_load = load[PctW-1:0];
         r.load = load[PctW-1:0];
      end
      r.interval = m_intv;
      return r;
   endfunction

   // Request driver.
   always @(negedge clock) begin
      if (!req_ch.valid || req_fire) begin
         if (queued_snaps.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            drive_snap = queued_snaps.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.mode <= drive_snap.mode;
            req_ch.total_time <= drive_snap.total;
            req_ch.busy_time <= drive_snap.busy;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Response receiver, including one long hold-off to back up the block.
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && req_count >= HOLD_AT) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Monitor and scoreboard.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("adaptive_refresh_interval test failed");
         $finish;
      end else begin
         req_fire = !reset && req_ch.valid && req_ch.ready;
         if (req_fire) begin
            due_reports.push_back(advance_interval({req_ch.mode, req_ch.total_time,
                                                    req_ch.busy_time}));
            req_count++;
         end
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (due_reports.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = due_reports.pop_front();
               if (rsp_ch.interval !== want.interval) begin
                  $error("interval: expected %0d, got %0d", want.interval, rsp_ch.interval);
                  fail_count++;
               end
               if (rsp_ch.changed !== want.changed) begin
                  $error("changed: expected %0d, got %0d", want.changed, rsp_ch.changed);
                  fail_count++;
               end
               if (rsp_ch.load_percent !== want.load) begin
                  $error("load_percent: expected %0d, got %0d", want.load,
                         rsp_ch.load_percent);
                  fail_count++;
               end
            end
         end
      end
   end

   task automatic add_snap(logic mode, logic [TimeW-1:0] total, logic [TimeW-1:0] busy);
      snapshot_type s;
      s.mode = mode;
      s.total = total;
      s.busy = busy;
      queued_snaps.push_back(s);
      run_total = total;
      run_busy = busy;
   endtask

   task automatic write_reg(csr_index_type idx, logic [CsrDataW-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_ENABLE: m_enable = value[0];
         CSR_BASE:   m_base = value[BaseW-1:0];
         CSR_HIGH:   m_high = value[PctW-1:0];
         CSR_LOW:    m_low = value[PctW-1:0];
         CSR_MIN:    m_min = value[IntvW-1:0];
         CSR_MAX:    m_max = value[IntvW-1:0];
         default:    ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_config(logic en, logic [CsrDataW-1:0] base, logic [CsrDataW-1:0] high,
                             logic [CsrDataW-1:0] low, logic [CsrDataW-1:0] lo_lim,
                             logic [CsrDataW-1:0] hi_lim);
      write_reg(CSR_ENABLE, CsrDataW'(en));
      write_reg(CSR_BASE, base);
      write_reg(CSR_HIGH, high);
      write_reg(CSR_LOW, low);
      write_reg(CSR_MIN, lo_lim);
      write_reg(CSR_MAX, hi_lim);
   endtask

   task automatic wait_quiet();
      while (queued_snaps.size() != 0 || req_ch.valid || due_reports.size() != 0)
         @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   // Mostly well-formed counter sequences whose load stays in one band for a
   // while, mixed with restarts and arbitrary snapshots.
   task automatic gen_burst(int count);
      int                 pct;
      int                 seg_left;
      int                 pick;
      logic [TimeW-1:0]   td;
      logic [TimeW-1:0]   bd;
      logic [2*TimeW-1:0] wide;
      pct = 0;
      seg_left = 0;
      repeat (count) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(3, 12);
            case ($urandom_range(4))
               0: pct = $urandom_range(0, 5);
               1: pct = $urandom_range(95, 100);
               2: pct = int'(m_high) + $urandom_range(0, 2) - 1;
               3: pct = int'(m_low) + $urandom_range(0, 2) - 1;
               default: pct = $urandom_range(0, 100);
            endcase
            if (pct < 0) pct = 0;
         end
         seg_left--;
         pick = $urandom_range(99);
         if (pick < 3) begin
            add_snap(MODE_RESTART, {$urandom, $urandom}, {$urandom, $urandom});
         end else if (pick < 6) begin
            add_snap(MODE_RESTART, run_total, run_busy);
         end else if (pick < 11) begin
            add_snap(MODE_SAMPLE, {$urandom, $urandom}, {$urandom, $urandom});
         end else begin
            case ($urandom_range(9))
               0: td = '0;
               1: td = {$urandom, $urandom};
               2: td = $urandom_range(1, 5);
               default: td = $urandom_range(1, 200000);
            endcase
            wide = {{TimeW{1'b0}}, td};
            wide = wide * pct;
            wide = wide / 100;
            bd = wide[TimeW-1:0];
            if ($urandom_range(3) == 0) bd = bd + $urandom_range(0, 3);
            add_snap(MODE_SAMPLE, run_total + td, run_busy + bd);
         end
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.mode = MODE_SAMPLE;
      req_ch.total_time = '0;
      req_ch.busy_time = '0;
      rsp_ch.ready = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_snap(MODE_SAMPLE, 64'd0, 64'd0);
      add_snap(MODE_RESTART, 64'd0, 64'd0);
      add_snap(MODE_SAMPLE, 64'd1000, 64'd900);
      add_snap(MODE_SAMPLE, 64'd2000, 64'd1800);
      add_snap(MODE_SAMPLE, 64'd3000, 64'd2700);
      add_snap(MODE_SAMPLE, 64'd4000, 64'd5000);
      add_snap(MODE_SAMPLE, 64'd5000, 64'd5000);
      add_snap(MODE_SAMPLE, 64'd6000, 64'd5000);
      add_snap(MODE_SAMPLE, 64'd7000, 64'd5000);
      add_snap(MODE_SAMPLE, 64'd7000, 64'd5000);
      add_snap(MODE_SAMPLE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      add_snap(MODE_SAMPLE, 64'd999, 64'd400);
      add_snap(MODE_SAMPLE, 64'h8000_0000_0000_03E7, 64'h3000_0000_0000_0000);
      add_snap(MODE_SAMPLE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA);
      add_snap(MODE_RESTART, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      add_snap(MODE_SAMPLE, 64'd100, 64'd99);
      add_snap(MODE_SAMPLE, 64'h5555_5555_5555_5555, 64'd0);
      add_snap(MODE_RESTART, 64'd0, 64'd0);
      add_snap(MODE_SAMPLE, 64'd100, 64'd22);
      add_snap(MODE_SAMPLE, 64'd200, 64'd45);
      add_snap(MODE_SAMPLE, 64'd300, 64'd68);
      gen_burst(200);
      wait_quiet();

      set_config(1'b1, 18'd10, 18'd50, 18'd30, 18'd0, 18'h3FFFF);
      gen_burst(300);
      wait_quiet();
      set_config(1'b1, 18'h3FFFF, 18'd22, 18'd18, 18'd0, 18'h3FFFF);
      gen_burst(200);
      wait_quiet();
      set_config(1'b1, 18'd0, 18'd0, 18'd100, 18'd0, 18'h3FFFF);
      gen_burst(150);
      wait_quiet();
      set_config(1'b1, 18'd3000, 18'd100, 18'd0, 18'd0, 18'd0);
      gen_burst(150);
      wait_quiet();
      set_config(1'b0, 18'd500, 18'd10, 18'd5, 18'd100, 18'd2000);
      gen_burst(150);
      wait_quiet();
      set_config(1'b1, 18'd1000, 18'd40, 18'd60, 18'h3FFFF, 18'h3FFFF);
      gen_burst(200);
      wait_quiet();
      set_config(1'b1, 18'd5000, 18'd127, 18'd127, 18'd7000, 18'd6000);
      gen_burst(200);
      wait_quiet();
      set_config(1'b1, 18'd2000, 18'd10, 18'd5, 18'd2100, 18'd3900);
      gen_burst(250);
      wait_quiet();
      set_config(1'b1, 18'd3000, 18'd22, 18'd18, 18'd1000, 18'd100000);
      gen_burst(150);
      wait_quiet();

      if (fail_count == 0 && due_reports.size() == 0) begin
         $display("adaptive_refresh_interval test passed");
      end else begin
         $display("adaptive_refresh_interval test failed");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/arf_pkg.sv
rtl/arf_req_if.sv
rtl/arf_rsp_if.sv
rtl/arf_csr.sv
rtl/arf_ctrl.sv
rtl/arf_dp.sv
rtl/adaptive_refresh_interval.sv
bench/tb.sv
